// ===== src/lwm_pkg.sv =====
`timescale 1ns / 1ps

package lwm_pkg;

  // field widths
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned COLOR_W = 8;

  // register file
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVE_LENGTH    = 2'd0,
    CFG_WAVE_GAP       = 2'd1,
    CFG_CYCLE_DURATION = 2'd2,
    CFG_STRIP_LENGTH   = 2'd3
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] WAVE_LENGTH_RST    = 16'd100;
  localparam logic [CFG_W-1:0] WAVE_GAP_RST       = 16'd100;
  localparam logic [CFG_W-1:0] CYCLE_DURATION_RST = 16'd50;
  localparam logic [CFG_W-1:0] STRIP_LENGTH_RST   = 16'd60;

  // ramp is phase * 512 / wave_length
  localparam int unsigned RAMP_SHIFT = 9;

  // exact floor(t / 255) for 16-bit t: (t * 0x8081) >> 23
  localparam int unsigned     CURVE_W      = 16;
  localparam logic [15:0]     DIV255_MAGIC = 16'h8081;
  localparam int unsigned     DIV255_SHIFT = 23;
  localparam int unsigned     MAGIC_PROD_W = 32;
  localparam logic [8:0]      CURVE_MAX    = 9'd255;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

endpackage

// ===== src/lwm_div_pipe.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per register stage
module lwm_div_pipe #(
  parameter int unsigned NUM_W  = 56,
  parameter int unsigned DEN_W  = 16,
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quot_o,
  output logic [DEN_W-1:0]  rem_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned WORK_W = DEN_W + NUM_W;

  // one step: shift in the next dividend bit, subtract if it fits
  function automatic logic [WORK_W-1:0] div_step(input logic [WORK_W-1:0] w,
                                                 input logic [DEN_W-1:0]  d);
    logic [DEN_W:0]   t;
    logic [DEN_W:0]   diff;
    logic             qb;
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] num;
    t    = {w[WORK_W-1:NUM_W], w[NUM_W-1]};
    diff = t - {1'b0, d};
    qb   = (t >= {1'b0, d});
    rem  = qb ? diff[DEN_W-1:0] : t[DEN_W-1:0];
    num  = {w[NUM_W-2:0], qb};
    return {rem, num};
  endfunction

  logic [NUM_W-1:0]  valid_q;
  logic [WORK_W-1:0] work_q [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              valid_d;
    logic [WORK_W-1:0] work_d;
    logic [SIDE_W-1:0] side_d;

    // stage input
    if (k == 0) begin : g_first
      assign valid_d = valid_i;
      assign work_d  = div_step({{DEN_W{1'b0}}, num_i}, den_i);
      assign side_d  = side_i;
    end else begin : g_next
      assign valid_d = valid_q[k-1];
      assign work_d  = div_step(work_q[k-1], den_i);
      assign side_d  = side_q[k-1];
    end

    // valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_d;
      end
    end

    // partial remainder, quotient bits and carried item data
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        work_q[k] <= work_d;
        side_q[k] <= side_d;
      end
    end
  end

  assign valid_o = valid_q[NUM_W-1];
  assign quot_o  = work_q[NUM_W-1][NUM_W-1:0];
  assign rem_o   = work_q[NUM_W-1][WORK_W-1:NUM_W];
  assign side_o  = side_q[NUM_W-1];

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (den_i != '0) |-> rem_o < den_i)
    else $error("divider remainder not below divisor");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i && valid_o |=> valid_o && $stable(quot_o) && $stable(rem_o))
    else $error("divider output moved while stalled");

endmodule

// ===== src/lwm_shade.sv =====
`timescale 1ns / 1ps

// ramp fold, square curve and channel scaling
module lwm_shade #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic                            dark_i,
  input  logic [lwm_pkg::RAMP_SHIFT+FRAC_BITS-1:0] ramp_i,
  input  lwm_pkg::rgb_t                   rgb_i,
  output logic                            valid_o,
  output lwm_pkg::rgb_t                   rgb_o
);

  import lwm_pkg::*;

  localparam int unsigned RAMP_W = RAMP_SHIFT + FRAC_BITS;
  localparam int unsigned FOLD_W = RAMP_W - 1;
  localparam int unsigned SQ_W   = 2 * FOLD_W;
  localparam logic [RAMP_W-1:0] RAMP_HALF = RAMP_W'(255) << FRAC_BITS;
  localparam logic [RAMP_W-1:0] RAMP_TOP  = RAMP_W'(511) << FRAC_BITS;

  logic d_valid_q, e_valid_q, f_valid_q, valid_q;
  logic d_dark_q, e_dark_q, f_dark_q;
  rgb_t d_rgb_q, e_rgb_q, f_rgb_q, rgb_q;
  logic [FOLD_W-1:0]       fold_d, d_fold_q;
  logic [SQ_W-1:0]         sq_d, e_sq_q;
  logic [MAGIC_PROD_W-1:0] magic_d, f_magic_q;
  logic [8:0]              curve_raw;
  logic [8:0]              gain;
  logic [COLOR_W+8:0]      red_prod, green_prod, blue_prod;
  rgb_t                    rgb_d;

  // fold the falling half of the ramp, clamp below zero
  always_comb begin
    if (ramp_i > RAMP_TOP) begin
      fold_d = '0;
    end else if (ramp_i > RAMP_HALF) begin
      fold_d = FOLD_W'(RAMP_TOP - ramp_i);
    end else begin
      fold_d = ramp_i[FOLD_W-1:0];
    end
  end

  // square of the ramp
  assign sq_d = d_fold_q * d_fold_q;

  // whole part of the square, divided by 255 through the reciprocal
  assign magic_d = e_sq_q[2*FRAC_BITS +: CURVE_W] * DIV255_MAGIC;

  // saturate the curve and scale each channel by (1 + s) / 256
  always_comb begin
    curve_raw  = f_magic_q[DIV255_SHIFT +: 9];
    gain       = ((curve_raw > CURVE_MAX) ? CURVE_MAX : curve_raw) + 9'd1;
    red_prod   = f_rgb_q.red * gain;
    green_prod = f_rgb_q.green * gain;
    blue_prod  = f_rgb_q.blue * gain;
    if (f_dark_q) begin
      rgb_d = '0;
    end else begin
      rgb_d.red   = red_prod[8 +: COLOR_W];
      rgb_d.green = green_prod[8 +: COLOR_W];
      rgb_d.blue  = blue_prod[8 +: COLOR_W];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
      valid_q   <= 1'b0;
    end else if (en_i) begin
      d_valid_q <= valid_i;
      e_valid_q <= d_valid_q;
      f_valid_q <= e_valid_q;
      valid_q   <= f_valid_q;
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_fold_q  <= fold_d;
      d_dark_q  <= dark_i;
      d_rgb_q   <= rgb_i;
      e_sq_q    <= sq_d;
      e_dark_q  <= d_dark_q;
      e_rgb_q   <= d_rgb_q;
      f_magic_q <= magic_d;
      f_dark_q  <= e_dark_q;
      f_rgb_q   <= e_rgb_q;
      rgb_q     <= rgb_d;
    end
  end

  assign valid_o = valid_q;
  assign rgb_o   = rgb_q;

  a_dark_is_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && f_valid_q && f_dark_q |=> valid_q && (rgb_q == '0))
    else $error("item in the dark gap did not come out black");

endmodule

// ===== src/led_wave_mask_unit.sv =====
`timescale 1ns / 1ps

// channel  direction  handshake                 payload
// in       sink       in_valid_i / in_stall_o   tick_count, led_index, red/green/blue_in
// out      source     out_valid_o / out_stall_i red/green/blue_out
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one item enters per clock while in_stall_o is low; the three dividers, one quotient
// bit per stage, are position, phase modulo and ramp
// the whole pipeline moves on one enable; it halts only while a result waits
// at the output and out_stall_i is high, and then in_stall_o is high too
// reset clears the valid bits and loads the register defaults; cfg is always ready

module led_wave_mask_unit #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lwm_pkg::TICK_W-1:0]          tick_count_i,
  input  logic [lwm_pkg::IDX_W-1:0]           led_index_i,
  input  logic [lwm_pkg::COLOR_W-1:0]         red_in_i,
  input  logic [lwm_pkg::COLOR_W-1:0]         green_in_i,
  input  logic [lwm_pkg::COLOR_W-1:0]         blue_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lwm_pkg::COLOR_W-1:0]         red_out_o,
  output logic [lwm_pkg::COLOR_W-1:0]         green_out_o,
  output logic [lwm_pkg::COLOR_W-1:0]         blue_out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lwm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lwm_pkg::CFG_W-1:0]           cfg_data_i
);

  import lwm_pkg::*;

  localparam int unsigned PROD_W  = TICK_W + CFG_W;
  localparam int unsigned NUM1_W  = PROD_W + FRAC_BITS;
  localparam int unsigned SUM_W   = NUM1_W + 1;
  localparam int unsigned PER_W   = CFG_W + 1 + FRAC_BITS;
  localparam int unsigned LIT_W   = CFG_W + FRAC_BITS;
  localparam int unsigned NUM3_W  = LIT_W + RAMP_SHIFT;
  localparam int unsigned RAMP_W  = RAMP_SHIFT + FRAC_BITS;
  localparam int unsigned RGB_W   = $bits(rgb_t);
  localparam int unsigned SIDE1_W = IDX_W + RGB_W;
  localparam int unsigned SIDE3_W = 1 + RGB_W;

  logic en;

  // configuration registers
  logic [CFG_W-1:0] wave_length_q, wave_gap_q, cycle_duration_q, strip_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_length_q    <= WAVE_LENGTH_RST;
      wave_gap_q       <= WAVE_GAP_RST;
      cycle_duration_q <= CYCLE_DURATION_RST;
      strip_length_q   <= STRIP_LENGTH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WAVE_LENGTH:    wave_length_q    <= cfg_data_i;
        CFG_WAVE_GAP:       wave_gap_q       <= cfg_data_i;
        CFG_CYCLE_DURATION: cycle_duration_q <= cfg_data_i;
        CFG_STRIP_LENGTH:   strip_length_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // global pipeline enable
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // stage a: tick times strip length
  logic              a_valid_q;
  logic [PROD_W-1:0] a_prod_q;
  logic [IDX_W-1:0]  a_idx_q;
  rgb_t              a_rgb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_prod_q      <= tick_count_i * strip_length_q;
      a_idx_q       <= led_index_i;
      a_rgb_q.red   <= red_in_i;
      a_rgb_q.green <= green_in_i;
      a_rgb_q.blue  <= blue_in_i;
    end
  end

  // position quotient over cycle duration, zero taken as one
  logic [CFG_W-1:0]   dur;
  logic               p_valid;
  logic [NUM1_W-1:0]  p_quot;
  logic [SIDE1_W-1:0] p_side;

  assign dur = (cycle_duration_q == '0) ? CFG_W'(1) : cycle_duration_q;

  lwm_div_pipe #(
    .NUM_W  (NUM1_W),
    .DEN_W  (CFG_W),
    .SIDE_W (SIDE1_W)
  ) u_pos_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (a_valid_q),
    .num_i   ({a_prod_q, {FRAC_BITS{1'b0}}}),
    .den_i   (dur),
    .side_i  ({a_idx_q, a_rgb_q}),
    .valid_o (p_valid),
    .quot_o  (p_quot),
    .rem_o   (),
    .side_o  (p_side)
  );

  // stage b: add the led offset
  logic             b_valid_q;
  logic [SUM_W-1:0] b_sum_q;
  rgb_t             b_rgb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= p_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_sum_q <= {1'b0, p_quot}
               + SUM_W'({p_side[SIDE1_W-1 -: IDX_W], {FRAC_BITS{1'b0}}});
      b_rgb_q <= p_side[RGB_W-1:0];
    end
  end

  // phase modulo the wave period
  logic [PER_W-1:0] period;
  logic             m_valid;
  logic [PER_W-1:0] m_phase;
  logic [RGB_W-1:0] m_side;

  assign period = {({1'b0, wave_length_q} + {1'b0, wave_gap_q}), {FRAC_BITS{1'b0}}};

  lwm_div_pipe #(
    .NUM_W  (SUM_W),
    .DEN_W  (PER_W),
    .SIDE_W (RGB_W)
  ) u_phase_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_valid_q),
    .num_i   (b_sum_q),
    .den_i   (period),
    .side_i  (b_rgb_q),
    .valid_o (m_valid),
    .quot_o  (),
    .rem_o   (m_phase),
    .side_o  (m_side)
  );

  // stage c: dark gap test and ramp dividend
  logic              c_valid_q;
  logic              c_dark_q;
  logic [NUM3_W-1:0] c_num_q;
  rgb_t              c_rgb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en) begin
      c_valid_q <= m_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_dark_q <= (m_phase >= {1'b0, wave_length_q, {FRAC_BITS{1'b0}}});
      c_num_q  <= {m_phase[LIT_W-1:0], {RAMP_SHIFT{1'b0}}};
      c_rgb_q  <= m_side;
    end
  end

  // ramp over the wavelength
  logic               r_valid;
  logic [NUM3_W-1:0]  r_quot;
  logic [SIDE3_W-1:0] r_side;

  lwm_div_pipe #(
    .NUM_W  (NUM3_W),
    .DEN_W  (CFG_W),
    .SIDE_W (SIDE3_W)
  ) u_ramp_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_valid_q),
    .num_i   (c_num_q),
    .den_i   (wave_length_q),
    .side_i  ({c_dark_q, c_rgb_q}),
    .valid_o (r_valid),
    .quot_o  (r_quot),
    .rem_o   (),
    .side_o  (r_side)
  );

  // curve and scaling
  rgb_t out_rgb;

  lwm_shade #(
    .FRAC_BITS (FRAC_BITS)
  ) u_shade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r_valid),
    .dark_i  (r_side[SIDE3_W-1]),
    .ramp_i  (r_quot[RAMP_W-1:0]),
    .rgb_i   (r_side[RGB_W-1:0]),
    .valid_o (out_valid_o),
    .rgb_o   (out_rgb)
  );

  assign red_out_o   = out_rgb.red;
  assign green_out_o = out_rgb.green;
  assign blue_out_o  = out_rgb.blue;

endmodule
